/* rtl/core/rpsl_pkg.sv */
// ----------------------------------------------------------------------------
// rpsl_pkg: shared constants, types and tables
// Widths, fixed-point constants, the arctangent table and the side-band
// types that travel with each item through the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rpsl_pkg;

  localparam int COORD_BITS      = 16;
  localparam int LEN_BITS        = 15;
  localparam int ANGLE_BITS      = 16;
  localparam int ANGLE_FRAC_BITS = 13;

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_FRAC  = 30;
  localparam int TRIG_FRAC    = 28;
  localparam int ZW           = 34;
  localparam int XW           = 34;
  localparam int TRIG_W       = 32;

  localparam int DIFF_W    = COORD_BITS + 1;
  localparam int PROD_W    = DIFF_W + TRIG_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int ROT_W     = SUM_W - TRIG_FRAC;
  localparam int E_W       = COORD_BITS + 3;
  localparam int MAG_W     = E_W;
  localparam int SQ_W      = 2 * E_W;
  localparam int RAD_SHIFT = 16;
  localparam int RAD_W     = SQ_W + RAD_SHIFT;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int NP_W      = LEN_BITS + MAG_W;
  localparam int NUM_W     = NP_W + RAD_SHIFT;
  localparam int Q_W       = LEN_BITS + 9;
  localparam int FRAC_OUT  = 8;

  localparam int CORDIC_LAT = CORDIC_STEPS + 2;
  localparam int ISQRT_LAT  = ROOT_W;
  localparam int DIV_LAT    = Q_W;
  localparam int PIPE_LAT   = CORDIC_LAT + 5 + ISQRT_LAT + DIV_LAT + 2;

  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [XW-1:0] INV_GAIN    = 34'sd652032874;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ci;
    logic signed [COORD_BITS-1:0] cj;
    logic signed [DIFF_W-1:0]     dx;
    logic signed [DIFF_W-1:0]     dy;
    logic        [LEN_BITS-1:0]   w;
  } entry_side_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ci;
    logic signed [COORD_BITS-1:0] cj;
    logic        [NP_W-1:0]       n_i;
    logic        [NP_W-1:0]       n_j;
    logic                         neg_i;
    logic                         neg_j;
    logic                         deg;
  } root_side_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ci;
    logic signed [COORD_BITS-1:0] cj;
    logic                         neg_i;
    logic                         neg_j;
    logic                         deg;
  } div_side_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int k);
    logic signed [ZW-1:0] a;
    unique case (k)
      0:  a = 34'sd843314856;
      1:  a = 34'sd497837829;
      2:  a = 34'sd263043836;
      3:  a = 34'sd133525158;
      4:  a = 34'sd67021686;
      5:  a = 34'sd33543515;
      6:  a = 34'sd16775850;
      7:  a = 34'sd8388437;
      8:  a = 34'sd4194282;
      9:  a = 34'sd2097149;
      10: a = 34'sd1048575;
      11: a = 34'sd524287;
      12: a = 34'sd262143;
      13: a = 34'sd131071;
      14: a = 34'sd65535;
      15: a = 34'sd32767;
      16: a = 34'sd16383;
      17: a = 34'sd8191;
      18: a = 34'sd4095;
      19: a = 34'sd2047;
      20: a = 34'sd1023;
      21: a = 34'sd511;
      22: a = 34'sd255;
      23: a = 34'sd127;
      24: a = 34'sd63;
      25: a = 34'sd31;
      26: a = 34'sd15;
      27: a = 34'sd8;
      28: a = 34'sd4;
      29: a = 34'sd2;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/rpsl_ifs.sv */
// ----------------------------------------------------------------------------
// rpsl_ifs: channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpsl_in_if import rpsl_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pivot_i;
  logic signed [COORD_BITS-1:0] pivot_j;
  logic signed [COORD_BITS-1:0] point_i;
  logic signed [COORD_BITS-1:0] point_j;
  logic        [LEN_BITS-1:0]   target_length;
  logic signed [ANGLE_BITS-1:0] rotation_angle;

  modport source (output valid, pivot_i, pivot_j, point_i, point_j, target_length,
                  rotation_angle, input ready);
  modport sink (input valid, pivot_i, pivot_j, point_i, point_j, target_length,
                rotation_angle, output ready);
endinterface

interface rpsl_out_if import rpsl_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] result_i;
  logic signed [COORD_BITS-1:0] result_j;
  logic                         degenerate;
  logic                         saturated;

  modport source (output valid, result_i, result_j, degenerate, saturated, input ready);
  modport sink (input valid, result_i, result_j, degenerate, saturated, output ready);
endinterface

`default_nettype wire

/* rtl/core/rpsl_cordic.sv */
// ----------------------------------------------------------------------------
// rpsl_cordic: pipelined cosine and sine
// Reduces the angle into the half-pi range and runs one CORDIC rotation per
// stage, giving cosine and sine in Q28.
// ----------------------------------------------------------------------------
`default_nettype none

module rpsl_cordic import rpsl_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         vld_i,
  input  logic signed [ANGLE_BITS-1:0] angle_i,
  output logic                         vld_o,
  output logic signed [TRIG_W-1:0]     cos_o,
  output logic signed [TRIG_W-1:0]     sin_o
);

  localparam int ZSHIFT = CORDIC_FRAC - ANGLE_FRAC_BITS;

  logic signed [ZW-1:0] z_in;
  logic signed [ZW-1:0] z_red;
  logic                 flip_red;
  logic signed [XW-1:0] x_r [CORDIC_STEPS+1];
  logic signed [XW-1:0] y_r [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z_r [CORDIC_STEPS+1];
  logic                 flip_r [CORDIC_STEPS+1];
  logic                 vld_r [CORDIC_STEPS+2];
  logic signed [XW-1:0] x_f;
  logic signed [XW-1:0] y_f;
  logic signed [XW-1:0] x_q;
  logic signed [XW-1:0] y_q;
  logic signed [TRIG_W-1:0] cos_r;
  logic signed [TRIG_W-1:0] sin_r;

  always_comb begin
    z_in = ZW'(angle_i) <<< ZSHIFT;
    unique if (z_in > HALF_PI_Q30) begin
      z_red    = z_in - PI_Q30;
      flip_red = 1'b1;
    end else if (z_in < -HALF_PI_Q30) begin
      z_red    = z_in + PI_Q30;
      flip_red = 1'b1;
    end else begin
      z_red    = z_in;
      flip_red = 1'b0;
    end
  end

  always_comb begin
    x_f = flip_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
    y_f = flip_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];
    x_q = x_f >>> 2;
    y_q = y_f >>> 2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= INV_GAIN;
      y_r[0]    <= '0;
      z_r[0]    <= z_red;
      flip_r[0] <= flip_red;
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        if (!z_r[k][ZW-1]) begin
          x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] - atan_q30(k);
        end else begin
          x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] + atan_q30(k);
        end
        flip_r[k+1] <= flip_r[k];
      end
      cos_r <= TRIG_W'(x_q);
      sin_r <= TRIG_W'(y_q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CORDIC_STEPS + 2; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= vld_i;
      for (int k = 1; k < CORDIC_STEPS + 2; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign vld_o = vld_r[CORDIC_STEPS+1];
  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

`default_nettype wire

/* rtl/core/rpsl_isqrt.sv */
// ----------------------------------------------------------------------------
// rpsl_isqrt: pipelined integer square root
// One root bit per stage, digit by digit, giving the floor of the square root.
// ----------------------------------------------------------------------------
`default_nettype none

module rpsl_isqrt import rpsl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic              vld_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int REM_W = ROOT_W + 3;

  logic [RAD_W-1:0]  rad_r    [ROOT_W];
  logic [REM_W-1:0]  rem_r    [ROOT_W];
  logic [ROOT_W-1:0] root_r   [ROOT_W];
  logic              vld_r    [ROOT_W];
  logic [RAD_W-1:0]  rad_in   [ROOT_W];
  logic [REM_W-1:0]  rem_in   [ROOT_W];
  logic [ROOT_W-1:0] root_in  [ROOT_W];
  logic [REM_W-1:0]  rem_sh   [ROOT_W];
  logic [REM_W-1:0]  trial    [ROOT_W];
  logic [RAD_W-1:0]  rad_nxt  [ROOT_W];
  logic [REM_W-1:0]  rem_nxt  [ROOT_W];
  logic [ROOT_W-1:0] root_nxt [ROOT_W];

  always_comb begin
    rad_in[0]  = rad_i;
    rem_in[0]  = '0;
    root_in[0] = '0;
    for (int k = 1; k < ROOT_W; k++) begin
      rad_in[k]  = rad_r[k-1];
      rem_in[k]  = rem_r[k-1];
      root_in[k] = root_r[k-1];
    end
    for (int k = 0; k < ROOT_W; k++) begin
      rem_sh[k]  = {rem_in[k][REM_W-3:0], rad_in[k][RAD_W-1 -: 2]};
      trial[k]   = REM_W'({root_in[k], 2'b01});
      rad_nxt[k] = rad_in[k] << 2;
      if (rem_sh[k] >= trial[k]) begin
        rem_nxt[k]  = rem_sh[k] - trial[k];
        root_nxt[k] = {root_in[k][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = rem_sh[k];
        root_nxt[k] = {root_in[k][ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ROOT_W; k++) begin
        rad_r[k]  <= rad_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ROOT_W; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= vld_i;
      for (int k = 1; k < ROOT_W; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign vld_o  = vld_r[ROOT_W-1];
  assign root_o = root_r[ROOT_W-1];

endmodule

`default_nettype wire

/* rtl/core/rpsl_div.sv */
// ----------------------------------------------------------------------------
// rpsl_div: pipelined two-lane divider
// Restoring division of two numerators by one shared divisor, one quotient
// bit per stage, most significant bit first.
// ----------------------------------------------------------------------------
`default_nettype none

module rpsl_div import rpsl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [ROOT_W-1:0] d_i,
  input  logic [NUM_W-1:0]  num_i [2],
  output logic              vld_o,
  output logic [Q_W-1:0]    q_o [2]
);

  localparam int DW = NUM_W + 1;

  logic [ROOT_W-1:0] d_r     [Q_W];
  logic [NUM_W-1:0]  rem_r   [Q_W][2];
  logic [Q_W-1:0]    q_r     [Q_W][2];
  logic              vld_r   [Q_W];
  logic [ROOT_W-1:0] d_in    [Q_W];
  logic [NUM_W-1:0]  rem_in  [Q_W][2];
  logic [Q_W-1:0]    q_in    [Q_W][2];
  logic [DW-1:0]     dd      [Q_W];
  logic [NUM_W-1:0]  rem_nxt [Q_W][2];
  logic [Q_W-1:0]    q_nxt   [Q_W][2];

  always_comb begin
    d_in[0] = d_i;
    for (int l = 0; l < 2; l++) begin
      rem_in[0][l] = num_i[l];
      q_in[0][l]   = '0;
    end
    for (int k = 1; k < Q_W; k++) begin
      d_in[k] = d_r[k-1];
      for (int l = 0; l < 2; l++) begin
        rem_in[k][l] = rem_r[k-1][l];
        q_in[k][l]   = q_r[k-1][l];
      end
    end
    for (int k = 0; k < Q_W; k++) begin
      dd[k] = DW'(d_in[k]) << (Q_W - 1 - k);
      for (int l = 0; l < 2; l++) begin
        if (DW'(rem_in[k][l]) >= dd[k]) begin
          rem_nxt[k][l] = NUM_W'(DW'(rem_in[k][l]) - dd[k]);
          q_nxt[k][l]   = q_in[k][l] | (Q_W'(1) << (Q_W - 1 - k));
        end else begin
          rem_nxt[k][l] = rem_in[k][l];
          q_nxt[k][l]   = q_in[k][l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < Q_W; k++) begin
        d_r[k] <= d_in[k];
        for (int l = 0; l < 2; l++) begin
          rem_r[k][l] <= rem_nxt[k][l];
          q_r[k][l]   <= q_nxt[k][l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < Q_W; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= vld_i;
      for (int k = 1; k < Q_W; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign vld_o  = vld_r[Q_W-1];
  assign q_o[0] = q_r[Q_W-1][0];
  assign q_o[1] = q_r[Q_W-1][1];

endmodule

`default_nettype wire

/* rtl/core/rotate_point_set_length.sv */
// ----------------------------------------------------------------------------
// rotate_point_set_length: rotate a point about a pivot and set its length
// Rotates the point by a Q2.13 angle, then places the result on the ray from
// the pivot at the requested distance, with saturation and a degenerate flag.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake      payload
//   in_ch     in          valid/ready    pivot, point, target_length, angle
//   out_ch    out         valid/ready    result_i, result_j, flags
//
// One item is taken per cycle while no result waits at the output. The pipeline
// includes the 30 CORDIC stages, the 27 square-root stages and the 24 divider
// stages. The whole pipeline advances together and holds while a result waits
// at the output. Reset clears all valid bits; there is no clearing pass.
//
`default_nettype none

module rotate_point_set_length import rpsl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rpsl_in_if.sink     in_ch,
  rpsl_out_if.source  out_ch
);

  localparam int T_W = Q_W + 2;
  localparam int R_W = T_W - FRAC_OUT;
  localparam logic signed [R_W-1:0] R_HI = R_W'(2 ** (COORD_BITS - 1) - 1);
  localparam logic signed [R_W-1:0] R_LO = -(R_W'(2 ** (COORD_BITS - 1)));

  logic en;

  entry_side_t side_r [CORDIC_LAT];
  entry_side_t side_nxt;
  entry_side_t side_o;

  logic                     trig_vld;
  logic signed [TRIG_W-1:0] cos_w;
  logic signed [TRIG_W-1:0] sin_w;

  logic                         a_vld_r;
  logic signed [PROD_W-1:0]     a_xc_r, a_ys_r, a_xs_r, a_yc_r;
  logic signed [COORD_BITS-1:0] a_ci_r, a_cj_r;
  logic        [LEN_BITS-1:0]   a_w_r;

  logic                         b_vld_r;
  logic signed [SUM_W-1:0]      b_sum_i_r, b_sum_j_r;
  logic signed [COORD_BITS-1:0] b_ci_r, b_cj_r;
  logic        [LEN_BITS-1:0]   b_w_r;

  logic signed [ROT_W-1:0]      rot_i, rot_j;
  logic                         c_vld_r;
  logic signed [E_W-1:0]        c_e_i_r, c_e_j_r;
  logic signed [COORD_BITS-1:0] c_ci_r, c_cj_r;
  logic        [LEN_BITS-1:0]   c_w_r;

  logic [MAG_W-1:0]             mag_i, mag_j;
  logic                         d_vld_r;
  logic [SQ_W-1:0]              d_sq_i_r, d_sq_j_r;
  logic [MAG_W-1:0]             d_mag_i_r, d_mag_j_r;
  logic                         d_neg_i_r, d_neg_j_r, d_deg_r;
  logic signed [COORD_BITS-1:0] d_ci_r, d_cj_r;
  logic        [LEN_BITS-1:0]   d_w_r;

  logic              e_vld_r;
  logic [RAD_W-1:0]  e_rad_r;
  root_side_t        rside_r [ISQRT_LAT+1];
  root_side_t        rside_nxt;
  root_side_t        rside_o;

  logic              root_vld;
  logic [ROOT_W-1:0] root_w;

  logic [NUM_W-1:0]  num_w [2];
  logic              div_vld;
  logic [Q_W-1:0]    q_w [2];
  div_side_t         dside_r [DIV_LAT];
  div_side_t         dside_o;

  logic signed [Q_W:0]          v_i, v_j;
  logic                         f_vld_r;
  logic signed [T_W-1:0]        f_t_i_r, f_t_j_r;
  logic signed [COORD_BITS-1:0] f_ci_r, f_cj_r;
  logic                         f_deg_r;

  logic signed [R_W-1:0]        r_i, r_j;
  logic signed [COORD_BITS-1:0] res_i_nxt, res_j_nxt;
  logic                         sat_nxt;

  logic                         out_vld_r;
  logic signed [COORD_BITS-1:0] out_ri_r, out_rj_r;
  logic                         out_deg_r, out_sat_r;

  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  always_comb begin
    side_nxt.ci = in_ch.pivot_i;
    side_nxt.cj = in_ch.pivot_j;
    side_nxt.dx = DIFF_W'(in_ch.point_i) - DIFF_W'(in_ch.pivot_i);
    side_nxt.dy = DIFF_W'(in_ch.point_j) - DIFF_W'(in_ch.pivot_j);
    side_nxt.w  = in_ch.target_length;
  end

  rpsl_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (in_ch.valid),
    .angle_i (in_ch.rotation_angle),
    .vld_o   (trig_vld),
    .cos_o   (cos_w),
    .sin_o   (sin_w)
  );

  assign side_o = side_r[CORDIC_LAT-1];

  always_comb begin
    rot_i = $signed(b_sum_i_r[SUM_W-1:TRIG_FRAC])
          + ROT_W'(b_sum_i_r[SUM_W-1] && (|b_sum_i_r[TRIG_FRAC-1:0]));
    rot_j = $signed(b_sum_j_r[SUM_W-1:TRIG_FRAC])
          + ROT_W'(b_sum_j_r[SUM_W-1] && (|b_sum_j_r[TRIG_FRAC-1:0]));
    mag_i = MAG_W'(c_e_i_r[E_W-1] ? -c_e_i_r : c_e_i_r);
    mag_j = MAG_W'(c_e_j_r[E_W-1] ? -c_e_j_r : c_e_j_r);
  end

  always_comb begin
    rside_nxt.ci    = d_ci_r;
    rside_nxt.cj    = d_cj_r;
    rside_nxt.n_i   = NP_W'(d_w_r) * NP_W'(d_mag_i_r);
    rside_nxt.n_j   = NP_W'(d_w_r) * NP_W'(d_mag_j_r);
    rside_nxt.neg_i = d_neg_i_r;
    rside_nxt.neg_j = d_neg_j_r;
    rside_nxt.deg   = d_deg_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      for (int k = 1; k < CORDIC_LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end

      a_xc_r <= PROD_W'(side_o.dx) * PROD_W'(cos_w);
      a_ys_r <= PROD_W'(side_o.dy) * PROD_W'(sin_w);
      a_xs_r <= PROD_W'(side_o.dx) * PROD_W'(sin_w);
      a_yc_r <= PROD_W'(side_o.dy) * PROD_W'(cos_w);
      a_ci_r <= side_o.ci;
      a_cj_r <= side_o.cj;
      a_w_r  <= side_o.w;

      b_sum_i_r <= (SUM_W'(a_ci_r) <<< TRIG_FRAC) + SUM_W'(a_xc_r) - SUM_W'(a_ys_r);
      b_sum_j_r <= (SUM_W'(a_cj_r) <<< TRIG_FRAC) + SUM_W'(a_xs_r) + SUM_W'(a_yc_r);
      b_ci_r    <= a_ci_r;
      b_cj_r    <= a_cj_r;
      b_w_r     <= a_w_r;

      c_e_i_r <= E_W'(rot_i - ROT_W'(b_ci_r));
      c_e_j_r <= E_W'(rot_j - ROT_W'(b_cj_r));
      c_ci_r  <= b_ci_r;
      c_cj_r  <= b_cj_r;
      c_w_r   <= b_w_r;

      d_sq_i_r  <= SQ_W'(mag_i) * SQ_W'(mag_i);
      d_sq_j_r  <= SQ_W'(mag_j) * SQ_W'(mag_j);
      d_mag_i_r <= mag_i;
      d_mag_j_r <= mag_j;
      d_neg_i_r <= c_e_i_r[E_W-1];
      d_neg_j_r <= c_e_j_r[E_W-1];
      d_deg_r   <= (c_e_i_r == '0) && (c_e_j_r == '0);
      d_ci_r    <= c_ci_r;
      d_cj_r    <= c_cj_r;
      d_w_r     <= c_w_r;

      e_rad_r    <= RAD_W'(d_sq_i_r + d_sq_j_r) << RAD_SHIFT;
      rside_r[0] <= rside_nxt;
      for (int k = 1; k <= ISQRT_LAT; k++) begin
        rside_r[k] <= rside_r[k-1];
      end

      dside_r[0].ci    <= rside_o.ci;
      dside_r[0].cj    <= rside_o.cj;
      dside_r[0].neg_i <= rside_o.neg_i;
      dside_r[0].neg_j <= rside_o.neg_j;
      dside_r[0].deg   <= rside_o.deg;
      for (int k = 1; k < DIV_LAT; k++) begin
        dside_r[k] <= dside_r[k-1];
      end

      f_t_i_r <= (T_W'(dside_o.ci) <<< FRAC_OUT) + T_W'(v_i);
      f_t_j_r <= (T_W'(dside_o.cj) <<< FRAC_OUT) + T_W'(v_j);
      f_ci_r  <= dside_o.ci;
      f_cj_r  <= dside_o.cj;
      f_deg_r <= dside_o.deg;

      out_ri_r  <= res_i_nxt;
      out_rj_r  <= res_j_nxt;
      out_deg_r <= f_deg_r;
      out_sat_r <= sat_nxt;
    end
  end

  rpsl_isqrt u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (e_vld_r),
    .rad_i  (e_rad_r),
    .vld_o  (root_vld),
    .root_o (root_w)
  );

  assign rside_o  = rside_r[ISQRT_LAT];
  assign num_w[0] = NUM_W'(rside_o.n_i) << RAD_SHIFT;
  assign num_w[1] = NUM_W'(rside_o.n_j) << RAD_SHIFT;

  rpsl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (root_vld),
    .d_i   (root_w),
    .num_i (num_w),
    .vld_o (div_vld),
    .q_o   (q_w)
  );

  assign dside_o = dside_r[DIV_LAT-1];

  always_comb begin
    v_i = dside_o.neg_i ? -$signed({1'b0, q_w[0]}) : $signed({1'b0, q_w[0]});
    v_j = dside_o.neg_j ? -$signed({1'b0, q_w[1]}) : $signed({1'b0, q_w[1]});
  end

  always_comb begin
    r_i = $signed(f_t_i_r[T_W-1:FRAC_OUT])
        + R_W'(f_t_i_r[T_W-1] && (|f_t_i_r[FRAC_OUT-1:0]));
    r_j = $signed(f_t_j_r[T_W-1:FRAC_OUT])
        + R_W'(f_t_j_r[T_W-1] && (|f_t_j_r[FRAC_OUT-1:0]));
    sat_nxt = 1'b0;
    priority if (r_i > R_HI) begin
      res_i_nxt = R_HI[COORD_BITS-1:0];
      sat_nxt   = 1'b1;
    end else if (r_i < R_LO) begin
      res_i_nxt = R_LO[COORD_BITS-1:0];
      sat_nxt   = 1'b1;
    end else begin
      res_i_nxt = r_i[COORD_BITS-1:0];
    end
    priority if (r_j > R_HI) begin
      res_j_nxt = R_HI[COORD_BITS-1:0];
      sat_nxt   = 1'b1;
    end else if (r_j < R_LO) begin
      res_j_nxt = R_LO[COORD_BITS-1:0];
      sat_nxt   = 1'b1;
    end else begin
      res_j_nxt = r_j[COORD_BITS-1:0];
    end
    if (f_deg_r) begin
      res_i_nxt = f_ci_r;
      res_j_nxt = f_cj_r;
      sat_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      d_vld_r   <= 1'b0;
      e_vld_r   <= 1'b0;
      f_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r   <= trig_vld;
      b_vld_r   <= a_vld_r;
      c_vld_r   <= b_vld_r;
      d_vld_r   <= c_vld_r;
      e_vld_r   <= d_vld_r;
      f_vld_r   <= div_vld;
      out_vld_r <= f_vld_r;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.result_i   = out_ri_r;
  assign out_ch.result_j   = out_rj_r;
  assign out_ch.degenerate = out_deg_r;
  assign out_ch.saturated  = out_sat_r;

endmodule

`default_nettype wire

/* rtl/core/rpsl_checker.sv */
// ----------------------------------------------------------------------------
// rpsl_checker: port-level assertions
// Watches the channels of the top level and checks flow and flag rules.
// ----------------------------------------------------------------------------
`default_nettype none

module rpsl_checker import rpsl_pkg::*; (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [COORD_BITS-1:0] result_i,
  input logic signed [COORD_BITS-1:0] result_j,
  input logic                         degenerate,
  input logic                         saturated
);

  localparam int CNT_W = $clog2(PIPE_LAT + 2);

  logic [CNT_W-1:0] cnt_r;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(result_i) && $stable(result_j)
                                   && $stable(degenerate) && $stable(saturated)))
    else $error("result item changed while stalled");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input held off with an empty output");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(degenerate && saturated))
    else $error("degenerate result marked as saturated");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cnt_r != '0 && cnt_r <= CNT_W'(PIPE_LAT)))
    else $error("result item without a matching input item");

endmodule

bind rotate_point_set_length rpsl_checker u_rpsl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .result_i   (out_ch.result_i),
  .result_j   (out_ch.result_j),
  .degenerate (out_ch.degenerate),
  .saturated  (out_ch.saturated)
);

`default_nettype wire
